// ===== rtl/core/tbc_pkg.sv =====
package tbc_pkg;

  // Block geometry and cipher depth.
  localparam int unsigned NumBytes   = 16;
  localparam int unsigned KeyBytes   = 32;
  localparam int unsigned RoundCount = 14;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned BlockWidth = NumBytes * 8;
  localparam int unsigned CfgIdxWidth = 3;

  // Byte 0 of a block or of the key sits in the most significant bits.
  typedef logic [7:0]                  byte_t;
  typedef logic [0:NumBytes-1][7:0]    block_t;
  typedef logic [0:KeyBytes-1][7:0]    key_bytes_t;
  typedef logic [WordWidth-1:0]        word_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_KEY_WORD0 = 3'd0,
    CFG_KEY_WORD1 = 3'd1,
    CFG_KEY_WORD2 = 3'd2,
    CFG_KEY_WORD3 = 3'd3,
    CFG_IV_HIGH   = 3'd4,
    CFG_IV_LOW    = 3'd5
  } cfg_idx_e;

endpackage

// ===== rtl/core/tbc_lane.sv =====
module tbc_lane
  import tbc_pkg::*;
(
  input  byte_t x_i,
  input  byte_t k_i,
  output byte_t y_o
);

  byte_t keyed;
  byte_t rotated;
  byte_t times17;

  // Round key mix, then rotate left by one and XOR with 17 times the byte.
  assign keyed   = x_i ^ k_i;
  assign rotated = {keyed[6:0], keyed[7]};
  assign times17 = keyed + {keyed[3:0], 4'b0000};
  assign y_o     = rotated ^ times17;

endmodule

// ===== rtl/core/tbc_round.sv =====
module tbc_round
  import tbc_pkg::*;
(
  input  block_t state_i,
  input  block_t rkey_i,
  output block_t state_o
);

  block_t mixed;

  // One lane per byte does the key XOR and the byte mix; the lanes' results are
  // then merged by the byte permutation out[i] = s[(5i + 7) mod 16].
  for (genvar i = 0; i < NumBytes; i++) begin : g_lane
    localparam int unsigned Src = (5 * i + 7) % NumBytes;

    tbc_lane u_lane (
      .x_i (state_i[i]),
      .k_i (rkey_i[i]),
      .y_o (mixed[i])
    );

    assign state_o[i] = mixed[Src];
  end

endmodule

// ===== rtl/core/toy_block_cipher_ctr_core.sv =====
// Counter-mode engine around a toy 16-byte block cipher. Each data beat on the
// input stream is XORed with the encryption of a 128-bit big-endian counter and
// comes out on the output stream; the counter then advances by one modulo 2^128.
// A beat with tuser set reloads the counter from the IV registers before it is
// used. Encryption and decryption are the same operation. The 14 cipher rounds
// are unrolled into a pipeline with one register per round, each round built of
// 16 byte lanes and a permutation stage, followed by an output register. The
// block takes one beat per clock cycle; a stall on the output stream freezes the
// whole pipeline. Each result passes through the round registers and the output
// register to the output stream. Key and IV registers are written through the
// configuration channel only while no beat is in flight, a rule for the user that
// the block itself does not enforce; a new IV takes effect at the next restart.
module toy_block_cipher_ctr_core
  import tbc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  word_t                  cfg_data_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: data_high [63:0], data_low [127:64].
  input  logic [BlockWidth-1:0]  s_axis_tdata,
  // Fields from bit 0 up: restart [0].
  input  logic [0:0]             s_axis_tuser,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: result_high [63:0], result_low [127:64].
  output logic [BlockWidth-1:0]  m_axis_tdata
);

  // Configuration registers.
  key_bytes_t key_q;
  word_t      iv_high_q;
  word_t      iv_low_q;

  // Counter and pipeline.
  logic [BlockWidth-1:0] ctr_q;
  logic [BlockWidth-1:0] ctr_d;
  logic [BlockWidth-1:0] ctr_used;
  block_t                data_in;
  block_t                rkey      [RoundCount];
  block_t                round_out [RoundCount];
  block_t                state_q   [RoundCount];
  block_t                data_q    [RoundCount];
  logic [RoundCount-1:0] valid_q;
  logic [RoundCount-1:0] valid_d;
  block_t                res_q;
  logic                  res_valid_q;
  logic [BlockWidth-1:0] res_flat;
  logic                  advance;
  logic                  in_accept;
  logic                  cfg_write;

  // Round key byte i of round r is key[(16r + i) mod 32] ^ ((17r + i) mod 256).
  function automatic block_t round_key(key_bytes_t key, int unsigned rnd);
    block_t rk;
    for (int unsigned i = 0; i < NumBytes; i++) begin
      rk[i] = key[5'((NumBytes * rnd + i) % KeyBytes)] ^ 8'((17 * rnd + i) % 256);
    end
    return rk;
  endfunction

  // The configuration channel is always ready.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      iv_high_q <= '0;
      iv_low_q  <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_WORD0: key_q[0:7]   <= cfg_data_i;
        CFG_KEY_WORD1: key_q[8:15]  <= cfg_data_i;
        CFG_KEY_WORD2: key_q[16:23] <= cfg_data_i;
        CFG_KEY_WORD3: key_q[24:31] <= cfg_data_i;
        CFG_IV_HIGH:   iv_high_q    <= cfg_data_i;
        CFG_IV_LOW:    iv_low_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being drained.
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Counter selection and increment.
  assign ctr_used = s_axis_tuser[0] ? {iv_high_q, iv_low_q} : ctr_q;
  assign ctr_d    = ctr_used + {{(BlockWidth-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (in_accept) begin
      ctr_q <= ctr_d;
    end
  end

  // Incoming data in byte order, byte 0 of the block first.
  assign data_in = block_t'({s_axis_tdata[WordWidth-1:0],
                             s_axis_tdata[BlockWidth-1:WordWidth]});

  // Unrolled rounds.
  for (genvar k = 0; k < RoundCount; k++) begin : g_round
    assign rkey[k] = round_key(key_q, k);

    tbc_round u_round (
      .state_i (state_q[k]),
      .rkey_i  (rkey[k]),
      .state_o (round_out[k])
    );
  end

  // Valid bits shift along with the beats.
  always_comb begin
    valid_d[0] = in_accept;
    for (int unsigned k = 1; k < RoundCount; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q     <= valid_d;
      res_valid_q <= valid_q[RoundCount-1];
    end
  end

  // Pipeline payload; the last round's keystream is XORed into the data.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      state_q[0] <= block_t'(ctr_used);
      data_q[0]  <= data_in;
      for (int unsigned k = 1; k < RoundCount; k++) begin
        state_q[k] <= round_out[k-1];
        data_q[k]  <= data_q[k-1];
      end
      res_q <= round_out[RoundCount-1] ^ data_q[RoundCount-1];
    end
  end

  // Output beat, high half in the low bits of tdata.
  assign res_flat      = res_q;
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {res_flat[WordWidth-1:0], res_flat[BlockWidth-1:WordWidth]};

`ifndef SYNTHESIS
  // A held result must stop the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while the output register is stalled");

  // A restart beat enters the rounds with the IV as its counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser[0]) |=> (state_q[0] == $past({iv_high_q, iv_low_q})))
    else $error("restart beat did not take the IV as counter");

  // A plain beat advances the counter by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s_axis_tuser[0]) |=> (ctr_q == $past(ctr_q) + 128'd1))
    else $error("counter did not advance by one");

  // The counter only changes on an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(ctr_q))
    else $error("counter changed without an accepted beat");
`endif

endmodule

// ===== sim/tbc_ctr_checker.sv =====
// Watches the configuration, input and output channels of the counter-mode
// core, keeps its own copy of the key, IV and counter, predicts every output
// beat and compares it with what the core delivers.
module tbc_ctr_checker
  import tbc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  word_t                  cfg_data_i,

  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [BlockWidth-1:0]  s_tdata_i,
  input  logic [0:0]             s_tuser_i,

  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [BlockWidth-1:0]  m_tdata_i,

  output int                     fail_count_o,
  output int                     pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Round key offset per round and the byte permutation out[i] = s[(5i+7) mod 16].
  localparam int unsigned RoundKeyStep = 17;
  localparam int unsigned PermMul      = 5;
  localparam int unsigned PermAdd      = 7;

  typedef struct packed {
    word_t high;
    word_t low;
  } result_t;

  word_t   key_words [4];
  word_t   iv_high;
  word_t   iv_low;
  logic [BlockWidth-1:0] counter;
  result_t pending_results [$];
  int      errors;

  // Encrypts one counter block with the toy cipher.
  function automatic block_t ctr_keystream(input block_t ctr, input key_bytes_t key);
    block_t s;
    block_t t;
    byte_t  x;
    byte_t  rk;
    s = ctr;
    for (int r = 0; r < RoundCount; r++) begin
      for (int i = 0; i < NumBytes; i++) begin
        rk   = key[(NumBytes * r + i) % KeyBytes] ^ byte_t'(RoundKeyStep * r + i);
        x    = s[i] ^ rk;
        s[i] = {x[6:0], x[7]} ^ byte_t'(x * byte_t'(RoundKeyStep));
      end
      for (int i = 0; i < NumBytes; i++) begin
        t[i] = s[(PermMul * i + PermAdd) % NumBytes];
      end
      s = t;
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [BlockWidth-1:0] ks;
    logic [BlockWidth-1:0] blk;
    result_t exp_res;
    word_t   got_high;
    word_t   got_low;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_words[i] = '0;
      iv_high = '0;
      iv_low  = '0;
      counter = '0;
      errors  = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Register writes; indexes past the list are dropped by the core.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_KEY_WORD0: key_words[0] = cfg_data_i;
          CFG_KEY_WORD1: key_words[1] = cfg_data_i;
          CFG_KEY_WORD2: key_words[2] = cfg_data_i;
          CFG_KEY_WORD3: key_words[3] = cfg_data_i;
          CFG_IV_HIGH:   iv_high      = cfg_data_i;
          CFG_IV_LOW:    iv_low       = cfg_data_i;
          default: ;
        endcase
      end

      // Output beat: compare against the oldest prediction.
      if (m_tvalid_i && m_tready_i) begin
        got_high = m_tdata_i[WordWidth-1:0];
        got_low  = m_tdata_i[BlockWidth-1:WordWidth];
        if (pending_results.size() == 0) begin
          $error("unexpected output beat: result_high %h result_low %h", got_high, got_low);
          errors++;
        end else begin
          exp_res = pending_results.pop_front();
          if (got_high !== exp_res.high) begin
            $error("result_high: expected %h, got %h", exp_res.high, got_high);
            errors++;
          end
          if (got_low !== exp_res.low) begin
            $error("result_low: expected %h, got %h", exp_res.low, got_low);
            errors++;
          end
        end
      end

      // Input beat: optional reload, keystream, then counter advance.
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0]) counter = {iv_high, iv_low};
        blk = ctr_keystream(block_t'(counter),
                            key_bytes_t'({key_words[0], key_words[1],
                                          key_words[2], key_words[3]}));
        ks = blk;
        exp_res.high = s_tdata_i[WordWidth-1:0] ^ ks[BlockWidth-1:WordWidth];
        exp_res.low  = s_tdata_i[BlockWidth-1:WordWidth] ^ ks[WordWidth-1:0];
        pending_results = {pending_results, exp_res};
        counter = counter + 1'b1;
      end

      fail_count_o <= errors;
      pending_o    <= pending_results.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Stimulus and verdict for the counter-mode core. Prediction and comparison
// live in the checker instance.
module tb;

  import tbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxGap      = 14;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned TailCycles  = 32;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 33;
  localparam int unsigned HoldItems   = 40;
  localparam word_t       AllOnes     = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  word_t                  cfg_data = '0;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BlockWidth-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;

  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [BlockWidth-1:0]  m_tdata;

  int fail_count;
  int pending_count;

  // Flags shared between the stimulus and the output-side process.
  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;
  bit hold_off   = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  toy_block_cipher_ctr_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  tbc_ctr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  function automatic int unsigned draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Mostly random words, with the extremes mixed in now and then.
  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One beat on the configuration channel; valid is left high for the next write.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input word_t k0, input word_t k1, input word_t k2,
                              input word_t k3, input word_t ivh, input word_t ivl,
                              input bit stray);
    logic [CfgIdxWidth-1:0] stray_idx;
    stray_idx = CfgIdxWidth'($urandom_range(CFG_IV_LOW + 1, (1 << CfgIdxWidth) - 1));
    if (stray) write_reg(stray_idx, {$urandom, $urandom});
    write_reg(CFG_KEY_WORD0, k0);
    write_reg(CFG_KEY_WORD1, k1);
    write_reg(CFG_KEY_WORD2, k2);
    write_reg(CFG_KEY_WORD3, k3);
    write_reg(CFG_IV_HIGH, ivh);
    write_reg(CFG_IV_LOW, ivl);
    if (stray) write_reg(stray_idx, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Offers one data beat after a random gap; valid stays high if the next
  // beat follows without a gap.
  task automatic send_block(input word_t data_high, input word_t data_low, input bit restart);
    int unsigned gap;
    gap = draw_gap(src_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data_low, data_high};
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering data and waits until every predicted result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Output side: random stalls per beat, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = draw_gap(snk_steady);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned mode;
    word_t       ivh;
    word_t       ivl;
    bit          first;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: zero key, counter starting at zero without any restart.
    send_block('0, '0, 1'b0);
    send_block(AllOnes, AllOnes, 1'b0);
    send_block('0, AllOnes, 1'b0);
    wait_drained();

    // All-ones key and IV: the counter wraps from all ones to zero.
    program_regs(AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, 1'b1);
    send_block('0, '0, 1'b1);
    send_block(AllOnes, '0, 1'b0);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
    wait_drained();

    // Carry from the low counter half into the high half, then a restart mid-run.
    program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, AllOnes - 1'b1, 1'b0);
    send_block('0, '0, 1'b1);
    send_block(AllOnes, AllOnes, 1'b0);
    send_block('0, '0, 1'b0);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    send_block('0, '0, 1'b0);
    wait_drained();

    // New key and IV between runs: the key applies at once, the IV only at the
    // next restart.
    program_regs('0, AllOnes, '0, AllOnes, '0, '0, 1'b1);
    send_block(AllOnes, '0, 1'b0);
    send_block('0, AllOnes, 1'b0);
    send_block('0, '0, 1'b1);
    send_block(AllOnes, AllOnes, 1'b0);
    wait_drained();

    // Random phases, each with its own settings and idling pattern.
    for (int p = 0; p < RandPhases; p++) begin
      mode = $urandom_range(0, 3);
      ivh  = {$urandom, $urandom};
      ivl  = {$urandom, $urandom};
      case (mode)
        0: program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, ivh, ivl, 1'($urandom_range(0, 1)));
        1: program_regs('0, '0, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
        2: program_regs(AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes,
                        1'($urandom_range(0, 1)));
        default: program_regs({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, {$urandom, $urandom},
                              ($urandom_range(0, 1) != 0) ? AllOnes : ivh,
                              AllOnes - word_t'($urandom_range(0, 8)),
                              1'($urandom_range(0, 1)));
      endcase
      src_steady = ($urandom_range(0, 3) == 0);
      snk_steady = ($urandom_range(0, 3) == 0);
      first = ($urandom_range(0, 7) != 0);
      for (int n = 0; n < PhaseItems; n++) begin
        send_block(rand_word(), rand_word(), first || ($urandom_range(0, 15) == 0));
        first = 1'b0;
      end
      wait_drained();

      // Once, halfway: the output side holds off while data keeps coming,
      // so the pipeline fills and the input stalls.
      if (p == RandPhases / 2) begin
        src_steady = 1'b1;
        hold_off   = 1'b1;
        for (int n = 0; n < HoldItems; n++) begin
          send_block(rand_word(), rand_word(), $urandom_range(0, 15) == 0);
        end
        wait_drained();
      end
    end

    src_steady = 1'b0;
    snk_steady = 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tbc_pkg.sv
rtl/core/tbc_lane.sv
rtl/core/tbc_round.sv
rtl/core/toy_block_cipher_ctr_core.sv
sim/tbc_ctr_checker.sv
sim/tb.sv
